// ===== design/tcpqh_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpqh_pkg
// Shared types and sizes for the two-class priority queue with history:
// operation and status codes, storage depths and the command word that
// the front half hands to the back half.
// ----------------------------------------------------------------------------
package tcpqh_pkg;

  // Storage depths
  localparam int QUEUE_DEPTH   = 16;
  localparam int HISTORY_DEPTH = 32;
  localparam int CMD_DEPTH     = 2;

  // Derived widths
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int HW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int CW  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CCW = $clog2(CMD_DEPTH + 1);

  localparam int VALUE_W = 32;

  localparam logic signed [VALUE_W-1:0] THRESHOLD_RESET = 32'sd5000;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_DRAIN = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_QFULL = 2'd1,
    ST_EMPTY = 2'd2,
    ST_HFULL = 2'd3
  } status_e;

  // Classified request passed from front to back
  typedef struct packed {
    op_e                       op;
    logic                      is_high;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

// ===== design/two_class_priority_queue_with_history_top.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_queue_with_history_top
// Two-class strict priority queue whose dequeued values collect on a
// history stack that a drain request empties newest first.
// ----------------------------------------------------------------------------
// Each enqueue, dequeue or unused request yields one result, so such requests
// stream at one per cycle while the receiver takes every result; each passes
// the command queue, then the result register. A drain holds the back half
// until it has returned every history entry (at least one result), since the
// history stack gives up one entry per cycle; requests behind it wait in the
// two-entry command queue. The class threshold resets to 5000; the user must
// write it through its own port only while the block is idle; the block itself
// does not enforce this. Unwritten queue and history entries carry no reset.
// ----------------------------------------------------------------------------
module two_class_priority_queue_with_history_top
  import tcpqh_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic signed [VALUE_W-1:0] class_threshold_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                operation_i,
  input  logic signed [VALUE_W-1:0] item_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VALUE_W-1:0] out_value_o,
  output logic                      has_value_o,
  output logic [1:0]                status_o,
  output logic                      last_o
);

  logic fr_valid, fr_ready, bk_valid, bk_ready;
  cmd_t fr_cmd, bk_cmd;

  // Accept and classify requests
  tcpqh_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .class_threshold_i (class_threshold_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .item_value_i      (item_value_i),
    .cmd_ready_i       (fr_ready),
    .cmd_valid_o       (fr_valid),
    .cmd_o             (fr_cmd)
  );

  // Decouple front and back
  tcpqh_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_cmd)
  );

  // Carry out commands
  tcpqh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (bk_valid),
    .cmd_ready_o (bk_ready),
    .cmd_i       (bk_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_value_o (out_value_o),
    .has_value_o (has_value_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

// ===== design/tcpqh_front.sv =====
// ----------------------------------------------------------------------------
// tcpqh_front
// Front half: holds the class threshold register, takes input requests
// and classifies enqueue values into the low or high class.
// ----------------------------------------------------------------------------
module tcpqh_front
  import tcpqh_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic signed [VALUE_W-1:0] class_threshold_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                operation_i,
  input  logic signed [VALUE_W-1:0] item_value_i,
  input  logic                      cmd_ready_i,
  output logic                      cmd_valid_o,
  output cmd_t                      cmd_o
);

  logic signed [VALUE_W-1:0] threshold_q;

  // Hold the threshold; writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      threshold_q <= class_threshold_i;
    end
  end

  // Classify the request and pass it on
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;

  always_comb begin
    cmd_o.op      = op_e'(operation_i);
    cmd_o.is_high = !(item_value_i < threshold_q);
    cmd_o.value   = item_value_i;
  end

endmodule

// ===== design/tcpqh_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// tcpqh_cmd_fifo
// Short command queue between front and back so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module tcpqh_cmd_fifo
  import tcpqh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  cmd_t           mem_q [CMD_DEPTH];
  logic [CW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CCW-1:0] cnt_q;
  logic           push, pop;

  assign push_ready_o = (cnt_q != CCW'(CMD_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == CW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == CW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/tcpqh_back.sv =====
// ----------------------------------------------------------------------------
// tcpqh_back
// Back half: carries out commands against the low and high ring buffers
// and the history stack, and drives the result register.
// ----------------------------------------------------------------------------
module tcpqh_back
  import tcpqh_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  cmd_t                      cmd_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VALUE_W-1:0] out_value_o,
  output logic                      has_value_o,
  output logic [1:0]                status_o,
  output logic                      last_o
);

  function automatic logic [QW-1:0] qptr_next(input logic [QW-1:0] p);
    return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic signed [VALUE_W-1:0] low_mem_q  [QUEUE_DEPTH];
  logic signed [VALUE_W-1:0] high_mem_q [QUEUE_DEPTH];
  logic signed [VALUE_W-1:0] hist_mem_q [HISTORY_DEPTH];

  logic [QW-1:0]  low_head_q, low_tail_q, high_head_q, high_tail_q;
  logic [QCW-1:0] low_cnt_q, high_cnt_q;
  logic [HCW-1:0] hist_cnt_q, hist_cnt_m1;
  logic [HW-1:0]  hist_wr_idx, hist_rd_idx;

  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      has_value_q, last_q;
  status_e                   status_q;

  logic                      step;
  logic                      low_full, high_full, low_any, high_any, hist_full;
  logic signed [VALUE_W-1:0] deq_val;
  logic                      low_push, high_push, low_pop, high_pop, hist_push, hist_pop;
  logic signed [VALUE_W-1:0] res_value;
  logic                      res_has, res_last;
  status_e                   res_status;

  assign low_full    = (low_cnt_q == QCW'(QUEUE_DEPTH));
  assign high_full   = (high_cnt_q == QCW'(QUEUE_DEPTH));
  assign low_any     = (low_cnt_q != '0);
  assign high_any    = (high_cnt_q != '0);
  assign hist_full   = (hist_cnt_q == HCW'(HISTORY_DEPTH));
  assign hist_cnt_m1 = hist_cnt_q - 1'b1;
  assign hist_rd_idx = hist_cnt_m1[HW-1:0];
  assign hist_wr_idx = hist_cnt_q[HW-1:0];
  assign deq_val     = low_any ? low_mem_q[low_head_q] : high_mem_q[high_head_q];

  // Work on the head command when the result register can take a result
  assign step        = cmd_valid_i && (!out_valid_q || out_ready_i);
  // Drop the command once its final result is produced
  assign cmd_ready_o = step && res_last;

  // Decode the command into updates and one result
  always_comb begin
    low_push   = 1'b0;
    high_push  = 1'b0;
    low_pop    = 1'b0;
    high_pop   = 1'b0;
    hist_push  = 1'b0;
    hist_pop   = 1'b0;
    res_value  = '0;
    res_has    = 1'b0;
    res_last   = 1'b1;
    res_status = ST_OK;
    case (cmd_i.op)
      OP_ENQ: begin
        if (cmd_i.is_high) begin
          if (high_full) res_status = ST_QFULL;
          else           high_push  = 1'b1;
        end else begin
          if (low_full) res_status = ST_QFULL;
          else          low_push   = 1'b1;
        end
      end
      OP_DEQ: begin
        if (!low_any && !high_any) begin
          res_status = ST_EMPTY;
        end else begin
          low_pop  = low_any;
          high_pop = !low_any;
          if (hist_full) res_status = ST_HFULL;
          else           hist_push  = 1'b1;
        end
      end
      OP_DRAIN: begin
        if (hist_cnt_q != '0) begin
          hist_pop  = 1'b1;
          res_value = hist_mem_q[hist_rd_idx];
          res_has   = 1'b1;
          res_last  = (hist_cnt_q == HCW'(1));
        end
      end
      default: ;
    endcase
  end

  // Write stores
  always_ff @(posedge clk_i) begin
    if (step && low_push) begin
      low_mem_q[low_tail_q] <= cmd_i.value;
    end
    if (step && high_push) begin
      high_mem_q[high_tail_q] <= cmd_i.value;
    end
    if (step && hist_push) begin
      hist_mem_q[hist_wr_idx] <= deq_val;
    end
  end

  // Advance ring pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_head_q  <= '0;
      low_tail_q  <= '0;
      low_cnt_q   <= '0;
      high_head_q <= '0;
      high_tail_q <= '0;
      high_cnt_q  <= '0;
      hist_cnt_q  <= '0;
    end else if (step) begin
      if (low_push) begin
        low_tail_q <= qptr_next(low_tail_q);
        low_cnt_q  <= low_cnt_q + 1'b1;
      end
      if (low_pop) begin
        low_head_q <= qptr_next(low_head_q);
        low_cnt_q  <= low_cnt_q - 1'b1;
      end
      if (high_push) begin
        high_tail_q <= qptr_next(high_tail_q);
        high_cnt_q  <= high_cnt_q + 1'b1;
      end
      if (high_pop) begin
        high_head_q <= qptr_next(high_head_q);
        high_cnt_q  <= high_cnt_q - 1'b1;
      end
      if (hist_push) begin
        hist_cnt_q <= hist_cnt_q + 1'b1;
      end
      if (hist_pop) begin
        hist_cnt_q <= hist_cnt_m1;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_value_q <= res_value;
      has_value_q <= res_has;
      status_q    <= res_status;
      last_q      <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign has_value_o = has_value_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

// ===== tb/sv/two_class_priority_queue_with_history_top_tb.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_queue_with_history_top_tb
// Self-checking bench for the two-class priority queue with history stack.
// A driver feeds requests from a backlog and mirrors every accepted request
// in a behavioral copy of both FIFOs and the history stack. A monitor
// compares each returned result field by field against the oldest predicted
// one. Phases under different class thresholds cover queue overflow, empty
// dequeues, history overflow and drains. Both sides idle at random, and one
// phase runs a long receiver hold-off so that the block backs up.
// ----------------------------------------------------------------------------
module two_class_priority_queue_with_history_top_tb;
  import tcpqh_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 200;
  localparam int END_CYCLES  = 20;
  localparam int IDLE_CYCLES = 4;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      has_value;
    status_e                   status;
    logic                      last;
  } queue_result_t;

  // Block ports
  logic                      clk_i             = 1'b0;
  logic                      rst_ni            = 1'b0;
  logic                      cfg_valid_i       = 1'b0;
  logic                      cfg_ready_o;
  logic signed [VALUE_W-1:0] class_threshold_i = THRESHOLD_RESET;
  logic                      in_valid_i        = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                operation_i       = OP_NONE;
  logic signed [VALUE_W-1:0] item_value_i      = '0;
  logic                      out_valid_o;
  logic                      out_ready_i       = 1'b0;
  logic signed [VALUE_W-1:0] out_value_o;
  logic                      has_value_o;
  logic [1:0]                status_o;
  logic                      last_o;

  // Request backlog and results still owed by the block
  request_t      op_backlog[$];
  queue_result_t owed_results[$];

  // Shadow copy of the block state
  logic signed [VALUE_W-1:0] cur_threshold = THRESHOLD_RESET;
  logic signed [VALUE_W-1:0] low_vals  [QUEUE_DEPTH];
  logic signed [VALUE_W-1:0] high_vals [QUEUE_DEPTH];
  logic signed [VALUE_W-1:0] hist_vals [HISTORY_DEPTH];
  int low_head  = 0;
  int low_cnt   = 0;
  int high_head = 0;
  int high_cnt  = 0;
  int hist_cnt  = 0;

  // Run control
  int   fail_count     = 0;
  int   idle_cycles    = 0;
  int   send_gap       = 0;
  int   send_steady    = 0;
  int   recv_stall     = 0;
  int   recv_steady    = 0;
  logic sender_burst   = 1'b0;
  logic long_hold_done = 1'b0;
  logic signed [VALUE_W-1:0] phase_threshold = THRESHOLD_RESET;

  two_class_priority_queue_with_history_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .class_threshold_i (class_threshold_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .item_value_i      (item_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_value_o       (out_value_o),
    .has_value_o       (has_value_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

  always #10 clk_i = ~clk_i;

  // Apply one request to the shadow state and queue the results it owes
  task automatic apply_queue_op(input logic [1:0] code,
                                input logic signed [VALUE_W-1:0] v);
    queue_result_t            res;
    logic signed [VALUE_W-1:0] popped;
    logic                      got;
    res    = '{value: '0, has_value: 1'b0, status: ST_OK, last: 1'b1};
    popped = '0;
    got    = 1'b0;
    case (op_e'(code))
      OP_ENQ: begin
        if (v < cur_threshold) begin
          if (low_cnt >= QUEUE_DEPTH) begin
            res.status = ST_QFULL;
          end else begin
            low_vals[(low_head + low_cnt) % QUEUE_DEPTH] = v;
            low_cnt++;
          end
        end else begin
          if (high_cnt >= QUEUE_DEPTH) begin
            res.status = ST_QFULL;
          end else begin
            high_vals[(high_head + high_cnt) % QUEUE_DEPTH] = v;
            high_cnt++;
          end
        end
        owed_results.push_back(res);
      end
      OP_DEQ: begin
        // Serve the low class first
        if (low_cnt != 0) begin
          popped   = low_vals[low_head];
          low_head = (low_head + 1) % QUEUE_DEPTH;
          low_cnt--;
          got      = 1'b1;
        end else if (high_cnt != 0) begin
          popped    = high_vals[high_head];
          high_head = (high_head + 1) % QUEUE_DEPTH;
          high_cnt--;
          got       = 1'b1;
        end
        if (!got) begin
          res.status = ST_EMPTY;
        end else if (hist_cnt >= HISTORY_DEPTH) begin
          res.status = ST_HFULL;
        end else begin
          hist_vals[hist_cnt] = popped;
          hist_cnt++;
        end
        owed_results.push_back(res);
      end
      OP_DRAIN: begin
        if (hist_cnt == 0) begin
          owed_results.push_back(res);
        end
        // Pop newest first, mark the oldest entry
        while (hist_cnt != 0) begin
          hist_cnt--;
          res.value     = hist_vals[hist_cnt];
          res.has_value = 1'b1;
          res.last      = (hist_cnt == 0);
          owed_results.push_back(res);
        end
      end
      default: begin
        owed_results.push_back(res);
      end
    endcase
  endtask

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) begin
      return $urandom_range(3, 1);
    end else if (roll < 96) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(60, 25);
  endfunction

  // Values near the threshold, at the extremes, small, or anywhere
  function automatic logic signed [VALUE_W-1:0] pick_value(
      input logic signed [VALUE_W-1:0] thr);
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(7))
      0, 1, 2: v = $urandom;
      3:       v = thr + $signed($urandom_range(3)) - 2;
      4:       v = {1'b1, {(VALUE_W-1){1'b0}}};
      5:       v = {1'b0, {(VALUE_W-1){1'b1}}};
      6:       v = $signed($urandom_range(200)) - 100;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_req(input logic [1:0] code, input logic signed [VALUE_W-1:0] v);
    request_t r;
    r.op    = code;
    r.value = v;
    op_backlog.push_back(r);
  endtask

  // Queue random requests with the given weights in percent
  task automatic add_random(input int n, input int w_enq, input int w_deq,
                            input int w_drain);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < w_enq) begin
        add_req(OP_ENQ, pick_value(phase_threshold));
      end else if (roll < w_enq + w_deq) begin
        add_req(OP_DEQ, $urandom);
      end else if (roll < w_enq + w_deq + w_drain) begin
        add_req(OP_DRAIN, $urandom);
      end else begin
        add_req(OP_NONE, $urandom);
      end
    end
  endtask

  // Hold until every request is sent and every result is back
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (op_backlog.size() != 0 || in_valid_i || owed_results.size() != 0);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic signed [VALUE_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    class_threshold_i <= v;
    phase_threshold    = v;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Request driver: mirror accepted requests, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin : driver
    request_t next_req;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      cur_threshold = THRESHOLD_RESET;
      low_head      = 0;
      low_cnt       = 0;
      high_head     = 0;
      high_cnt      = 0;
      hist_cnt      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cur_threshold = class_threshold_i;
      end
      if (in_valid_i && in_ready_o) begin
        apply_queue_op(operation_i, item_value_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (op_backlog.size() != 0) begin
          next_req      = op_backlog.pop_front();
          operation_i  <= next_req.op;
          item_value_i <= next_req.value;
          in_valid_i   <= 1'b1;
          // Pick the gap before the following request
          if (sender_burst) begin
            send_gap = 0;
          end else if (send_steady > 0) begin
            send_steady--;
            send_gap = 0;
          end else if ($urandom_range(99) < 4) begin
            send_steady = $urandom_range(60, 20);
            send_gap    = 0;
          end else if ($urandom_range(99) < 45) begin
            send_gap = 0;
          end else begin
            send_gap = gap_len();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check against the oldest owed result, then pace ready
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    queue_result_t want;
    int            roll;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (owed_results.size() == 0) begin
          $error("result with nothing owed: out_value %0d has_value %0b status %0d last %0b",
                 out_value_o, has_value_o, status_o, last_o);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_value_o !== want.value) begin
            $error("out_value expected %0d actual %0d", want.value, out_value_o);
            fail_count++;
          end
          if (has_value_o !== want.has_value) begin
            $error("has_value expected %0b actual %0b", want.has_value, has_value_o);
            fail_count++;
          end
          if (status_o !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status_o);
            fail_count++;
          end
          if (last_o !== want.last) begin
            $error("last expected %0b actual %0b", want.last, last_o);
            fail_count++;
          end
        end
      end
      // Hold off once for a long stretch when the sender streams
      if (sender_burst && !long_hold_done) begin
        recv_stall     = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (recv_stall > 0) begin
        recv_stall--;
      end else if (recv_steady > 0) begin
        recv_steady--;
      end else begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          recv_steady = $urandom_range(60, 20);
        end else if (roll < 30) begin
          recv_stall = gap_len();
        end
      end
      out_ready_i <= (recv_stall == 0);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("two_class_priority_queue_with_history_top_tb: FAIL");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: class boundary, extremes, both-empty dequeue, drains, unused code
    add_req(OP_ENQ, 32'sh8000_0000);
    add_req(OP_ENQ, 32'sh7fff_ffff);
    add_req(OP_ENQ, 32'sd4999);
    add_req(OP_ENQ, 32'sd5000);
    add_req(OP_ENQ, 32'sd0);
    add_req(OP_NONE, 32'sh7fff_ffff);
    repeat (6) add_req(OP_DEQ, 32'sh0);
    add_req(OP_DRAIN, 32'sh0);
    add_req(OP_DRAIN, 32'shffff_ffff);
    add_req(OP_ENQ, -32'sd1);
    add_req(OP_DEQ, 32'shffff_ffff);
    add_req(OP_DRAIN, 32'sh0);
    add_req(OP_NONE, 32'shffff_ffff);
    wait_drained();

    // Mixed traffic under the reset threshold
    add_random(80, 45, 35, 15);
    wait_drained();

    // Lowest threshold: everything lands in the high class, queue overflows
    write_threshold(32'sh8000_0000);
    add_random(80, 75, 20, 3);
    wait_drained();

    // Highest threshold: fill and empty the queue until history overflows
    write_threshold(32'sh7fff_ffff);
    repeat (3) begin
      repeat (18) add_req(OP_ENQ, pick_value(phase_threshold));
      repeat (18) add_req(OP_DEQ, $urandom);
    end
    add_req(OP_DRAIN, $urandom);
    add_random(30, 40, 55, 3);
    wait_drained();

    // Back-to-back requests against a long receiver hold-off
    write_threshold(32'sd0);
    sender_burst = 1'b1;
    add_random(80, 45, 35, 15);
    wait_drained();
    sender_burst = 1'b0;

    // Drain-heavy traffic under a random threshold
    write_threshold($urandom);
    add_random(80, 40, 30, 28);
    wait_drained();

    // Dequeue-heavy traffic just below zero
    write_threshold(-32'sd1);
    add_random(60, 40, 55, 3);
    wait_drained();

    repeat (END_CYCLES) @(posedge clk_i);
    if (owed_results.size() != 0) begin
      $error("%0d results never arrived", owed_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("two_class_priority_queue_with_history_top_tb: PASS");
    end else begin
      $display("two_class_priority_queue_with_history_top_tb: FAIL");
    end
    $finish;
  end

endmodule
